### sv/dmsp_pkg.sv
// Shared types, codes and constants of the distance move speed profile block.
// No dependencies; all files but dmsp_in_if, dmsp_out_if and dmsp_checker use this package.
package dmsp_pkg;

    localparam int MIN_SPEED_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_W      = 48;
    localparam int DEN_W      = 25;
    localparam int QUO_W      = 24;
    localparam int CNT_W      = 5;

    localparam logic [7:0] SPEED_LIMIT = 8'd100;
    localparam logic [7:0] CATCH_SCALE = 8'd100;

    // x / 100 as (x * CATCH_RECIP) >> CATCH_SHIFT, exact for x below 2^23
    localparam logic [23:0] CATCH_RECIP = 24'd10737419;
    localparam int          CATCH_SHIFT = 30;

    localparam logic [CNT_W-1:0] DIV_BITS_ACC   = 5'd24;
    localparam logic [CNT_W-1:0] DIV_BITS_RAMP  = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOVE_COUNTS,
        REG_DRIVE_SPEED,
        REG_IDEAL_ACCEL,
        REG_IDEAL_DECEL,
        REG_STOP_AT_END,
        REG_MAX_STEP,
        REG_CATCH_MIN,
        REG_CATCH_MAX
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_START_CHK,
        ST_ACC_DIV,
        ST_ACC_SET,
        ST_PEAK_CHK,
        ST_PEAK_DS,
        ST_PEAK_DIV,
        ST_PEAK_SET,
        ST_TRAV,
        ST_REM,
        ST_SEL,
        ST_RAMP_DS,
        ST_RAMP_DIV,
        ST_CUR_SET,
        ST_CLAMP,
        ST_CATCH_MUL,
        ST_CATCH_RECIP,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START_INIT,
        OP_RES_ZERO,
        OP_RES_IDLE,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ACC_SET,
        OP_PEAK_MUL,
        OP_PEAK_FULL,
        OP_PEAK_SET,
        OP_DELTA,
        OP_TRAV,
        OP_REM,
        OP_SEL,
        OP_CUR_SET,
        OP_CLAMP,
        OP_CATCH_MUL,
        OP_CATCH_RECIP,
        OP_FIN,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [CNT_W-1:0] div_bits;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_start;
        logic moving;
        logic tgt_zero;
        logic tgt_fits;
        logic peak_cut;
        logic need_div;
        logic div_last;
    } dp_status_t;

endpackage

### sv/dmsp_in_if.sv
// Input item channel: valid/ready handshake with command and encoder payload.
// Depends on nothing.
interface dmsp_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [7:0]  measured_speed;

    modport source (output valid, cmd, left_count, right_count, measured_speed, input ready);
    modport sink   (input valid, cmd, left_count, right_count, measured_speed, output ready);
endinterface

### sv/dmsp_out_if.sv
// Result item channel: valid/ready handshake with speed command and done flag.
// Depends on nothing.
interface dmsp_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] wheel_speed;
    logic              done_res;

    modport source (output valid, wheel_speed, done_res, input ready);
    modport sink   (input valid, wheel_speed, done_res, output ready);
endinterface

### sv/dmsp_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on dmsp_pkg for the field widths.
interface dmsp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dmsp_pkg::CFG_IDX_W-1:0]   index;
    logic [dmsp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/distance_move_speed_profile.sv
// Top level of the trapezoidal speed profile generator for a straight move.
// Depends on dmsp_pkg, the three channel interfaces, dmsp_ctrl and dmsp_dp.
//
//   channel | dir | payload                                         | accepted when
//   req     | in  | cmd, left_count, right_count, measured_speed    | valid && ready
//   rsp     | out | wheel_speed, done_res                           | valid && ready
//   cfg     | in  | index (register 0..7), data                     | valid && ready
//
// One item at a time; one result per item. A start item may use the 24-step
// span division and the 7-step peak division of the shared divider; a sample
// item of a moving profile may use the 7-step ramp division. A waiting result
// stalls only the final output step. Reset is asynchronous and needs no
// clearing pass.
module distance_move_speed_profile #(
    parameter int MIN_SPEED = dmsp_pkg::MIN_SPEED_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dmsp_in_if.sink    req,
    dmsp_out_if.source rsp,
    dmsp_cfg_if.sink   cfg
);

    dmsp_pkg::dp_cmd_t    cmd;
    dmsp_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    dmsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dmsp_dp #(
        .MIN_SPEED (MIN_SPEED)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_cmd    (req.cmd),
        .in_left   (req.left_count),
        .in_right  (req.right_count),
        .in_meas   (req.measured_speed),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_speed (rsp.wheel_speed),
        .out_done  (rsp.done_res)
    );

endmodule

### sv/dmsp_dp.sv
// Datapath: configuration registers, move state, shared multiplier and
// shift-subtract divider, driven by commands from dmsp_ctrl. Uses dmsp_pkg.
module dmsp_dp #(
    parameter int MIN_SPEED = dmsp_pkg::MIN_SPEED_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dmsp_pkg::dp_cmd_t               cmd,
    output dmsp_pkg::dp_status_t            status,
    input  logic                            in_cmd,
    input  logic signed [31:0]              in_left,
    input  logic signed [31:0]              in_right,
    input  logic        [7:0]               in_meas,
    input  logic                            cfg_we,
    input  logic [dmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic signed [7:0]               out_speed,
    output logic                            out_done
);

    localparam logic [6:0] MIN7 = 7'(MIN_SPEED);

    logic [23:0] move_reg, ia_reg, id_reg;
    logic [7:0]  drive_reg;
    logic        stop_reg;
    logic [6:0]  step_reg;
    logic [15:0] cmin_reg, cmax_reg;

    logic [31:0] mark_l_reg, mark_r_reg;
    logic [23:0] acc_reg, dec_reg;
    logic [6:0]  peak_reg;
    logic [7:0]  prev_reg;
    logic        moving_reg;

    logic                            cmd_reg;
    logic [31:0]                     lc_reg, rc_reg;
    logic [7:0]                      meas_reg;
    logic [32:0]                     dl_reg, dr_reg, trav_reg;
    logic signed [33:0]              rem_reg;
    logic [7:0]                      cur_reg;
    logic                            csign_reg;
    logic [dmsp_pkg::DIV_W-1:0]      prod_reg, rdiv_reg, dsh_reg;
    logic [dmsp_pkg::DEN_W-1:0]      den_reg;
    logic [dmsp_pkg::QUO_W-1:0]      q_reg;
    logic [dmsp_pkg::CNT_W-1:0]      cnt_reg;
    logic signed [7:0]               res_speed_reg, out_speed_reg;
    logic                            res_done_reg, out_done_reg;

    logic [7:0]  sp_mag;
    logic [6:0]  maxs, pdiff;
    logic [23:0] id_eff;
    logic [24:0] sum25;
    logic signed [32:0] diff_l, diff_r;
    logic [33:0] trav_sum;
    logic        up, down, peak_low, rem_pos, rem_lt_dec, rem_le_dec;
    logic        need_div;
    logic [7:0]  cur_direct;
    logic [23:0] mul_a, mul_b;
    logic [dmsp_pkg::DIV_W-1:0] prod_next;
    logic        ge;
    logic [8:0]  lim9;
    logic [7:0]  cur_clamp, vmax;
    logic [6:0]  v7;
    logic signed [16:0] cdiff;
    logic [15:0] cmag;
    logic signed [17:0] catch18;
    logic        fin;
    logic signed [7:0] speed_signed;

    always_comb
    begin
        sp_mag     = drive_reg[7] ? 8'(-drive_reg) : drive_reg;
        maxs       = (sp_mag > dmsp_pkg::SPEED_LIMIT) ? dmsp_pkg::SPEED_LIMIT[6:0] : sp_mag[6:0];
        pdiff      = (maxs >= MIN7) ? maxs - MIN7 : MIN7 - maxs;
        id_eff     = stop_reg ? id_reg : 24'd0;
        sum25      = {1'b0, ia_reg} + {1'b0, id_eff};
        diff_l     = $signed({lc_reg[31], lc_reg}) - $signed({mark_l_reg[31], mark_l_reg});
        diff_r     = $signed({rc_reg[31], rc_reg}) - $signed({mark_r_reg[31], mark_r_reg});
        trav_sum   = {1'b0, dl_reg} + {1'b0, dr_reg};
        up         = trav_reg < {9'd0, acc_reg};
        rem_le_dec = rem_reg <= $signed({10'd0, dec_reg});
        rem_lt_dec = rem_reg < $signed({10'd0, dec_reg});
        rem_pos    = !rem_reg[33] && (rem_reg != 34'sd0);
        down       = !up && stop_reg && rem_le_dec;
        peak_low   = peak_reg <= MIN7;
        need_div   = 1'b0;
        cur_direct = {1'b0, peak_reg};
        if (up)
        begin
            need_div = !peak_low;
        end
        else if (down)
        begin
            if (!peak_low && dec_reg != 24'd0 && rem_lt_dec)
            begin
                if (rem_pos)
                begin
                    need_div = 1'b1;
                end
                else
                begin
                    cur_direct = {1'b0, MIN7};
                end
            end
        end
        ge        = rdiv_reg >= dsh_reg;
        lim9      = {1'b0, prev_reg} + {2'b0, step_reg};
        cur_clamp = ({1'b0, cur_reg} > lim9) ? lim9[7:0] : cur_reg;
        vmax      = (meas_reg > cur_reg) ? meas_reg : cur_reg;
        v7        = (vmax > dmsp_pkg::CATCH_SCALE) ? dmsp_pkg::CATCH_SCALE[6:0] : vmax[6:0];
        cdiff     = $signed({1'b0, cmax_reg}) - $signed({1'b0, cmin_reg});
        cmag      = cdiff[16] ? 16'(-cdiff) : cdiff[15:0];
        catch18   = csign_reg ? $signed({2'b0, cmin_reg}) - $signed({2'b0, q_reg[15:0]})
                              : $signed({2'b0, cmin_reg}) + $signed({2'b0, q_reg[15:0]});
        fin       = !rem_pos || (stop_reg && rem_reg <= 34'(catch18));
        speed_signed = drive_reg[7] ? 8'(-cur_reg) : cur_reg;
        case (cmd.op)
            dmsp_pkg::OP_START_INIT:
            begin
                mul_a = move_reg;
                mul_b = ia_reg;
            end
            dmsp_pkg::OP_PEAK_MUL:
            begin
                mul_a = {17'd0, pdiff};
                mul_b = acc_reg;
            end
            dmsp_pkg::OP_SEL:
            begin
                mul_a = {17'd0, peak_reg - MIN7};
                mul_b = up ? trav_reg[23:0] : rem_reg[23:0];
            end
            dmsp_pkg::OP_CATCH_MUL:
            begin
                mul_a = {8'd0, cmag};
                mul_b = {17'd0, v7};
            end
            dmsp_pkg::OP_CATCH_RECIP:
            begin
                mul_a = prod_reg[23:0];
                mul_b = dmsp_pkg::CATCH_RECIP;
            end
            default:
            begin
                mul_a = 24'd0;
                mul_b = 24'd0;
            end
        endcase
        prod_next = 48'(mul_a) * 48'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_reg   <= '0;
            drive_reg  <= '0;
            ia_reg     <= '0;
            id_reg     <= '0;
            stop_reg   <= 1'b1;
            step_reg   <= 7'd5;
            cmin_reg   <= '0;
            cmax_reg   <= '0;
            mark_l_reg <= '0;
            mark_r_reg <= '0;
            acc_reg    <= '0;
            dec_reg    <= '0;
            peak_reg   <= '0;
            prev_reg   <= {1'b0, MIN7};
            moving_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (dmsp_pkg::cfg_reg_t'(cfg_index))
                    dmsp_pkg::REG_MOVE_COUNTS: move_reg  <= cfg_data;
                    dmsp_pkg::REG_DRIVE_SPEED: drive_reg <= cfg_data[7:0];
                    dmsp_pkg::REG_IDEAL_ACCEL: ia_reg    <= cfg_data;
                    dmsp_pkg::REG_IDEAL_DECEL: id_reg    <= cfg_data;
                    dmsp_pkg::REG_STOP_AT_END: stop_reg  <= cfg_data[0];
                    dmsp_pkg::REG_MAX_STEP:    step_reg  <= cfg_data[6:0];
                    dmsp_pkg::REG_CATCH_MIN:   cmin_reg  <= cfg_data[15:0];
                    dmsp_pkg::REG_CATCH_MAX:   cmax_reg  <= cfg_data[15:0];
                    default:                   move_reg  <= move_reg;
                endcase
            end
            case (cmd.op)
                dmsp_pkg::OP_START_INIT:
                begin
                    mark_l_reg <= lc_reg;
                    mark_r_reg <= rc_reg;
                    prev_reg   <= {1'b0, MIN7};
                    acc_reg    <= ia_reg;
                    dec_reg    <= id_eff;
                end
                dmsp_pkg::OP_RES_ZERO:
                    moving_reg <= 1'b0;
                dmsp_pkg::OP_ACC_SET:
                begin
                    acc_reg <= q_reg;
                    dec_reg <= move_reg - q_reg;
                end
                dmsp_pkg::OP_PEAK_FULL:
                begin
                    peak_reg   <= maxs;
                    moving_reg <= 1'b1;
                end
                dmsp_pkg::OP_PEAK_SET:
                begin
                    peak_reg   <= (maxs >= MIN7) ? MIN7 + q_reg[6:0] : MIN7 - q_reg[6:0];
                    moving_reg <= 1'b1;
                end
                dmsp_pkg::OP_CLAMP:
                    prev_reg <= cur_clamp;
                dmsp_pkg::OP_FIN:
                    if (fin)
                    begin
                        moving_reg <= 1'b0;
                    end
                default:
                    prev_reg <= prev_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dmsp_pkg::OP_LOAD:
            begin
                cmd_reg  <= in_cmd;
                lc_reg   <= in_left;
                rc_reg   <= in_right;
                meas_reg <= in_meas;
            end
            dmsp_pkg::OP_START_INIT:
            begin
                prod_reg <= prod_next;
                den_reg  <= sum25;
            end
            dmsp_pkg::OP_RES_ZERO, dmsp_pkg::OP_RES_IDLE:
            begin
                res_speed_reg <= '0;
                res_done_reg  <= 1'b1;
            end
            dmsp_pkg::OP_PEAK_FULL, dmsp_pkg::OP_PEAK_SET:
            begin
                res_speed_reg <= '0;
                res_done_reg  <= 1'b0;
            end
            dmsp_pkg::OP_DIV_START:
            begin
                rdiv_reg <= prod_reg;
                dsh_reg  <= 48'(den_reg) << (cmd.div_bits - 5'd1);
                q_reg    <= '0;
                cnt_reg  <= cmd.div_bits;
            end
            dmsp_pkg::OP_DIV_STEP:
            begin
                if (ge)
                begin
                    rdiv_reg <= rdiv_reg - dsh_reg;
                end
                q_reg   <= {q_reg[dmsp_pkg::QUO_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
            end
            dmsp_pkg::OP_PEAK_MUL:
            begin
                prod_reg <= prod_next;
                den_reg  <= {1'b0, ia_reg};
            end
            dmsp_pkg::OP_DELTA:
            begin
                dl_reg <= diff_l[32] ? 33'(-diff_l) : diff_l;
                dr_reg <= diff_r[32] ? 33'(-diff_r) : diff_r;
            end
            dmsp_pkg::OP_TRAV:
                trav_reg <= trav_sum[33:1];
            dmsp_pkg::OP_REM:
                rem_reg <= $signed({10'd0, move_reg}) - $signed({1'b0, trav_reg});
            dmsp_pkg::OP_SEL:
            begin
                cur_reg  <= cur_direct;
                prod_reg <= prod_next;
                den_reg  <= up ? {1'b0, acc_reg} : {1'b0, dec_reg};
            end
            dmsp_pkg::OP_CUR_SET:
                cur_reg <= {1'b0, MIN7 + q_reg[6:0]};
            dmsp_pkg::OP_CLAMP:
                cur_reg <= cur_clamp;
            dmsp_pkg::OP_CATCH_MUL:
            begin
                prod_reg  <= prod_next;
                csign_reg <= cdiff[16];
            end
            dmsp_pkg::OP_CATCH_RECIP:
                q_reg <= {8'd0, prod_next[dmsp_pkg::CATCH_SHIFT +: 16]};
            dmsp_pkg::OP_FIN:
            begin
                res_speed_reg <= fin ? 8'sd0 : speed_signed;
                res_done_reg  <= fin;
            end
            dmsp_pkg::OP_PUSH:
            begin
                out_speed_reg <= res_speed_reg;
                out_done_reg  <= res_done_reg;
            end
            default:
                cmd_reg <= cmd_reg;
        endcase
    end

    assign status.cmd_start = !cmd_reg;
    assign status.moving    = moving_reg;
    assign status.tgt_zero  = move_reg == 24'd0;
    assign status.tgt_fits  = {1'b0, move_reg} >= sum25;
    assign status.peak_cut  = (ia_reg != 24'd0) && (acc_reg < ia_reg);
    assign status.need_div  = need_div;
    assign status.div_last  = cnt_reg == 5'd1;

    assign out_speed = out_speed_reg;
    assign out_done  = out_done_reg;

endmodule

### sv/dmsp_ctrl.sv
// Controller: sequences the datapath through start and sample work and owns
// the handshake state of both item channels. Uses dmsp_pkg.
module dmsp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dmsp_pkg::dp_status_t status,
    output dmsp_pkg::dp_cmd_t    cmd
);

    dmsp_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmsp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = dmsp_pkg::OP_NONE;
        cmd.div_bits = '0;
        push         = 1'b0;
        case (state_reg)
            dmsp_pkg::ST_IDLE:
                if (in_valid)
                begin
                    cmd.op     = dmsp_pkg::OP_LOAD;
                    state_next = dmsp_pkg::ST_DECODE;
                end
            dmsp_pkg::ST_DECODE:
                if (status.cmd_start)
                begin
                    cmd.op     = dmsp_pkg::OP_START_INIT;
                    state_next = dmsp_pkg::ST_START_CHK;
                end
                else if (!status.moving)
                begin
                    cmd.op     = dmsp_pkg::OP_RES_IDLE;
                    state_next = dmsp_pkg::ST_OUT;
                end
                else
                begin
                    cmd.op     = dmsp_pkg::OP_DELTA;
                    state_next = dmsp_pkg::ST_TRAV;
                end
            dmsp_pkg::ST_START_CHK:
                if (status.tgt_zero)
                begin
                    cmd.op     = dmsp_pkg::OP_RES_ZERO;
                    state_next = dmsp_pkg::ST_OUT;
                end
                else if (status.tgt_fits)
                begin
                    state_next = dmsp_pkg::ST_PEAK_CHK;
                end
                else
                begin
                    cmd.op       = dmsp_pkg::OP_DIV_START;
                    cmd.div_bits = dmsp_pkg::DIV_BITS_ACC;
                    state_next   = dmsp_pkg::ST_ACC_DIV;
                end
            dmsp_pkg::ST_ACC_DIV:
            begin
                cmd.op = dmsp_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = dmsp_pkg::ST_ACC_SET;
                end
            end
            dmsp_pkg::ST_ACC_SET:
            begin
                cmd.op     = dmsp_pkg::OP_ACC_SET;
                state_next = dmsp_pkg::ST_PEAK_CHK;
            end
            dmsp_pkg::ST_PEAK_CHK:
                if (status.peak_cut)
                begin
                    cmd.op     = dmsp_pkg::OP_PEAK_MUL;
                    state_next = dmsp_pkg::ST_PEAK_DS;
                end
                else
                begin
                    cmd.op     = dmsp_pkg::OP_PEAK_FULL;
                    state_next = dmsp_pkg::ST_OUT;
                end
            dmsp_pkg::ST_PEAK_DS:
            begin
                cmd.op       = dmsp_pkg::OP_DIV_START;
                cmd.div_bits = dmsp_pkg::DIV_BITS_RAMP;
                state_next   = dmsp_pkg::ST_PEAK_DIV;
            end
            dmsp_pkg::ST_PEAK_DIV:
            begin
                cmd.op = dmsp_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = dmsp_pkg::ST_PEAK_SET;
                end
            end
            dmsp_pkg::ST_PEAK_SET:
            begin
                cmd.op     = dmsp_pkg::OP_PEAK_SET;
                state_next = dmsp_pkg::ST_OUT;
            end
            dmsp_pkg::ST_TRAV:
            begin
                cmd.op     = dmsp_pkg::OP_TRAV;
                state_next = dmsp_pkg::ST_REM;
            end
            dmsp_pkg::ST_REM:
            begin
                cmd.op     = dmsp_pkg::OP_REM;
                state_next = dmsp_pkg::ST_SEL;
            end
            dmsp_pkg::ST_SEL:
            begin
                cmd.op     = dmsp_pkg::OP_SEL;
                state_next = status.need_div ? dmsp_pkg::ST_RAMP_DS : dmsp_pkg::ST_CLAMP;
            end
            dmsp_pkg::ST_RAMP_DS:
            begin
                cmd.op       = dmsp_pkg::OP_DIV_START;
                cmd.div_bits = dmsp_pkg::DIV_BITS_RAMP;
                state_next   = dmsp_pkg::ST_RAMP_DIV;
            end
            dmsp_pkg::ST_RAMP_DIV:
            begin
                cmd.op = dmsp_pkg::OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = dmsp_pkg::ST_CUR_SET;
                end
            end
            dmsp_pkg::ST_CUR_SET:
            begin
                cmd.op     = dmsp_pkg::OP_CUR_SET;
                state_next = dmsp_pkg::ST_CLAMP;
            end
            dmsp_pkg::ST_CLAMP:
            begin
                cmd.op     = dmsp_pkg::OP_CLAMP;
                state_next = dmsp_pkg::ST_CATCH_MUL;
            end
            dmsp_pkg::ST_CATCH_MUL:
            begin
                cmd.op     = dmsp_pkg::OP_CATCH_MUL;
                state_next = dmsp_pkg::ST_CATCH_RECIP;
            end
            dmsp_pkg::ST_CATCH_RECIP:
            begin
                cmd.op     = dmsp_pkg::OP_CATCH_RECIP;
                state_next = dmsp_pkg::ST_FIN;
            end
            dmsp_pkg::ST_FIN:
            begin
                cmd.op     = dmsp_pkg::OP_FIN;
                state_next = dmsp_pkg::ST_OUT;
            end
            dmsp_pkg::ST_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = dmsp_pkg::OP_PUSH;
                    push       = 1'b1;
                    state_next = dmsp_pkg::ST_IDLE;
                end
            default:
                state_next = dmsp_pkg::ST_IDLE;
        endcase
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = state_reg == dmsp_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

### sv/dmsp_checker.sv
// Port-level checks of the speed profile block, attached by bind.
// Depends on distance_move_speed_profile and its channel interfaces.
module dmsp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic signed [7:0] wheel_speed,
    input logic              done_res
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(wheel_speed) && $stable(done_res))
        else $error("result changed while stalled");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && done_res |-> wheel_speed == 8'sd0)
        else $error("done result with nonzero speed");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> wheel_speed >= -8'sd100 && wheel_speed <= 8'sd100)
        else $error("speed out of range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while busy");

endmodule

bind distance_move_speed_profile dmsp_checker u_dmsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .wheel_speed (rsp.wheel_speed),
    .done_res    (rsp.done_res)
);

### tb/distance_move_speed_profile_checker.sv
// Checker for the distance move speed profile block: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on dmsp_pkg and the three channel interfaces.
module distance_move_speed_profile_checker #(
    parameter int MIN_SPEED = dmsp_pkg::MIN_SPEED_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dmsp_in_if   req,
    dmsp_out_if  rsp,
    dmsp_cfg_if  cfg,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [7:0] wheel_speed;
        logic              done_res;
    } speed_cmd_t;

    speed_cmd_t speed_q[$];

    logic [23:0] move_counts, ideal_accel, ideal_decel;
    logic [7:0]  drive_speed;
    logic        stop_at_end;
    logic [6:0]  max_step;
    logic [15:0] catch_min, catch_max;

    logic signed [31:0] mark_l, mark_r;
    logic [23:0]        accel_used, decel_used;
    int                 peak, prev_speed;
    logic               moving;

    assign pending = speed_q.size();

    function automatic int ramp_speed(longint pos, longint span, int pk, bit down);
        int s;
        if (pk <= MIN_SPEED) return pk;
        if (span <= 0 || pos >= span) return pk;
        if (down && pos <= 0) return MIN_SPEED;
        s = MIN_SPEED + int'(longint'(pk - MIN_SPEED) * pos / span);
        return s < MIN_SPEED ? MIN_SPEED : s;
    endfunction

    function automatic longint catch_span(int cur, int meas);
        longint v;
        v = meas > cur ? meas : cur;
        if (v < 0) v = 0;
        if (v > 100) v = 100;
        return longint'(catch_min) + (longint'(catch_max) - longint'(catch_min)) * v / 100;
    endfunction

    function automatic speed_cmd_t predict_speed(logic c, logic signed [31:0] lc,
                                                 logic signed [31:0] rc, logic [7:0] meas);
        speed_cmd_t r;
        int sp, maxs, cur, pk;
        longint tgt, ia, id, acc, dec, dl, dr, trav, rem;
        bit fin;
        r = '0;
        sp = int'($signed(drive_speed));
        if (!c)
        begin
            maxs = sp < 0 ? -sp : sp;
            if (maxs > 100) maxs = 100;
            tgt = move_counts;
            ia = ideal_accel;
            id = stop_at_end ? longint'(ideal_decel) : 0;
            prev_speed = MIN_SPEED;
            mark_l = lc;
            mark_r = rc;
            if (tgt == 0)
            begin
                moving = 1'b0;
                r.done_res = 1'b1;
                return r;
            end
            if (tgt >= ia + id)
            begin
                acc = ia;
                dec = id;
            end
            else
            begin
                acc = tgt * ia / (ia + id);
                dec = tgt - acc;
            end
            pk = maxs;
            if (ia > 0 && acc < ia)
                pk = MIN_SPEED + int'(longint'(maxs - MIN_SPEED) * acc / ia);
            accel_used = acc[23:0];
            decel_used = dec[23:0];
            peak = pk & 8'h7F;
            moving = 1'b1;
            return r;
        end
        if (!moving)
        begin
            r.done_res = 1'b1;
            return r;
        end
        dl = longint'(lc) - longint'(mark_l);
        dr = longint'(rc) - longint'(mark_r);
        if (dl < 0) dl = -dl;
        if (dr < 0) dr = -dr;
        trav = (dl + dr) / 2;
        rem = longint'(move_counts) - trav;
        if (trav < longint'(accel_used))
            cur = ramp_speed(trav, accel_used, peak, 1'b0);
        else if (stop_at_end && rem <= longint'(decel_used))
            cur = ramp_speed(rem, decel_used, peak, 1'b1);
        else
            cur = peak;
        if (cur > prev_speed + int'(max_step))
            cur = prev_speed + int'(max_step);
        prev_speed = cur & 8'hFF;
        if (stop_at_end)
            fin = rem <= 0 || rem <= catch_span(cur, meas);
        else
            fin = rem <= 0;
        if (fin)
        begin
            moving = 1'b0;
            r.done_res = 1'b1;
        end
        else
        begin
            r.wheel_speed = 8'((sp >= 0 ? 1 : -1) * cur);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        speed_cmd_t got, want;
        if (!rst_n)
        begin
            move_counts <= '0; drive_speed <= '0; ideal_accel <= '0; ideal_decel <= '0;
            stop_at_end <= 1'b1; max_step <= 7'd5; catch_min <= '0; catch_max <= '0;
            mark_l = '0; mark_r = '0; accel_used = '0; decel_used = '0;
            peak = 0; prev_speed = MIN_SPEED; moving = 1'b0;
            errors = 0;
            speed_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (dmsp_pkg::cfg_reg_t'(cfg.index))
                    dmsp_pkg::REG_MOVE_COUNTS: move_counts <= cfg.data;
                    dmsp_pkg::REG_DRIVE_SPEED: drive_speed <= cfg.data[7:0];
                    dmsp_pkg::REG_IDEAL_ACCEL: ideal_accel <= cfg.data;
                    dmsp_pkg::REG_IDEAL_DECEL: ideal_decel <= cfg.data;
                    dmsp_pkg::REG_STOP_AT_END: stop_at_end <= cfg.data[0];
                    dmsp_pkg::REG_MAX_STEP:    max_step    <= cfg.data[6:0];
                    dmsp_pkg::REG_CATCH_MIN:   catch_min   <= cfg.data[15:0];
                    dmsp_pkg::REG_CATCH_MAX:   catch_max   <= cfg.data[15:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                speed_q.push_back(predict_speed(req.cmd, req.left_count, req.right_count,
                                                req.measured_speed));
            if (rsp.valid && rsp.ready)
            begin
                got.wheel_speed = rsp.wheel_speed;
                got.done_res = rsp.done_res;
                if (speed_q.size() == 0)
                begin
                    report_mismatch("unexpected item", got.wheel_speed, 0);
                end
                else
                begin
                    want = speed_q.pop_front();
                    if (got.wheel_speed !== want.wheel_speed)
                        report_mismatch("wheel_speed", got.wheel_speed, want.wheel_speed);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                end
            end
        end
    end
endmodule

### tb/distance_move_speed_profile_test.sv
// Top of the distance move speed profile testbench: clock, reset, register
// writes, request stimulus and result back-pressure, and the final verdict.
// Depends on dmsp_pkg, the channel interfaces, the block and its checker.
module distance_move_speed_profile_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   errors, pending;
    int   send_idle, recv_stall;
    int   cycles;

    dmsp_in_if  req();
    dmsp_out_if rsp();
    dmsp_cfg_if cfg();

    distance_move_speed_profile DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    distance_move_speed_profile_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(negedge clk)
        rsp.ready = ($urandom_range(99) >= recv_stall);

    task automatic write_reg(dmsp_pkg::cfg_reg_t idx, logic [23:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_item(logic c, logic [31:0] lc, logic [31:0] rc, logic [7:0] meas);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.cmd = c;
        req.left_count = lc;
        req.right_count = rc;
        req.measured_speed = meas;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    task automatic run_move(int samples, int max_adv);
        logic [31:0] l, r;
        int sl, sr;
        l = $urandom;
        r = $urandom;
        sl = $urandom_range(1) ? 1 : -1;
        sr = $urandom_range(1) ? 1 : -1;
        send_item(1'b0, l, r, 8'($urandom));
        for (int i = 0; i < samples; i++)
        begin
            l = l + sl * $urandom_range(max_adv);
            r = r + sr * $urandom_range(max_adv);
            send_item(1'b1, l, r, 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(110)));
        end
    endtask

    task automatic random_config();
        logic [23:0] mc;
        case ($urandom_range(5))
            0:       mc = 24'hFFFFFF;
            1:       mc = 24'($urandom);
            default: mc = 24'($urandom_range(8000));
        endcase
        write_reg(dmsp_pkg::REG_MOVE_COUNTS, mc);
        write_reg(dmsp_pkg::REG_DRIVE_SPEED, $urandom_range(3) == 0 ? 24'($urandom_range(255))
                                             : 24'(8'($urandom_range(200) - 100)));
        write_reg(dmsp_pkg::REG_IDEAL_ACCEL,
                  $urandom_range(7) == 0 ? 24'($urandom) : 24'($urandom_range(3000)));
        write_reg(dmsp_pkg::REG_IDEAL_DECEL,
                  $urandom_range(7) == 0 ? 24'($urandom) : 24'($urandom_range(3000)));
        write_reg(dmsp_pkg::REG_STOP_AT_END, 24'($urandom_range(3) != 0));
        write_reg(dmsp_pkg::REG_MAX_STEP,
                  24'($urandom_range(5) == 0 ? $urandom_range(127) : $urandom_range(1, 20)));
        write_reg(dmsp_pkg::REG_CATCH_MIN,
                  24'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(200)));
        write_reg(dmsp_pkg::REG_CATCH_MAX,
                  24'($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(400)));
    endtask

    initial
    begin
        int mc_now, n;
        send_idle = 0;
        recv_stall = 0;
        req.valid = 1'b0; req.cmd = 1'b0; req.left_count = '0; req.right_count = '0;
        req.measured_speed = '0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(1'b1, 32'h0, 32'h0, 8'h00);
        send_item(1'b0, 32'h7FFFFFFF, 32'h80000000, 8'hFF);
        send_item(1'b1, 32'h7FFFFFFF, 32'h80000000, 8'hFF);
        drain();
        write_reg(dmsp_pkg::REG_MOVE_COUNTS, 24'd1000);
        write_reg(dmsp_pkg::REG_DRIVE_SPEED, 24'(8'sd100));
        write_reg(dmsp_pkg::REG_IDEAL_ACCEL, 24'd200);
        write_reg(dmsp_pkg::REG_IDEAL_DECEL, 24'd300);
        write_reg(dmsp_pkg::REG_STOP_AT_END, 24'd1);
        write_reg(dmsp_pkg::REG_MAX_STEP, 24'd5);
        write_reg(dmsp_pkg::REG_CATCH_MIN, 24'd5);
        write_reg(dmsp_pkg::REG_CATCH_MAX, 24'd40);
        send_item(1'b0, 32'h80000000, 32'h7FFFFFFF, 8'h00);
        send_item(1'b1, 32'h80000000, 32'h7FFFFFFF, 8'h00);
        send_item(1'b1, 32'h80000064, 32'h7FFFFF9B, 8'h00);
        send_item(1'b1, 32'h80000190, 32'h7FFFFE00, 8'hFF);
        send_item(1'b1, 32'h80000300, 32'h7FFFFD00, 8'h00);
        send_item(1'b1, 32'h800003E0, 32'h7FFFFC20, 8'h00);
        send_item(1'b1, 32'h0, 32'h0, 8'h00);
        drain();
        write_reg(dmsp_pkg::REG_MOVE_COUNTS, 24'hFFFFFF);
        write_reg(dmsp_pkg::REG_DRIVE_SPEED, 24'h000080);
        write_reg(dmsp_pkg::REG_IDEAL_ACCEL, 24'hFFFFFF);
        write_reg(dmsp_pkg::REG_IDEAL_DECEL, 24'hFFFFFF);
        write_reg(dmsp_pkg::REG_STOP_AT_END, 24'd0);
        write_reg(dmsp_pkg::REG_MAX_STEP, 24'd0);
        write_reg(dmsp_pkg::REG_CATCH_MIN, 24'hFFFF);
        write_reg(dmsp_pkg::REG_CATCH_MAX, 24'd0);
        send_item(1'b0, 32'h80000000, 32'h00000000, 8'h00);
        send_item(1'b1, 32'h7FFFFFFF, 32'hFFFFFFFF, 8'hFF);
        send_item(1'b1, 32'h00000000, 32'h7FFFFFFF, 8'h00);
        drain();
        write_reg(dmsp_pkg::REG_MOVE_COUNTS, 24'd500);
        write_reg(dmsp_pkg::REG_DRIVE_SPEED, 24'(8'h07));
        write_reg(dmsp_pkg::REG_STOP_AT_END, 24'd1);
        write_reg(dmsp_pkg::REG_MAX_STEP, 24'd127);
        write_reg(dmsp_pkg::REG_IDEAL_ACCEL, 24'd0);
        write_reg(dmsp_pkg::REG_IDEAL_DECEL, 24'd100);
        send_item(1'b0, 32'h0, 32'h0, 8'h00);
        send_item(1'b1, 32'd50, 32'd50, 8'h00);
        send_item(1'b1, 32'd480, 32'hFFFFFE20, 8'hFF);
        drain();

        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 88;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 88;
                end
                default:
                begin
                    send_idle = 8;
                    recv_stall = 8;
                end
            endcase
            random_config();
            mc_now = 0;
            n = 0;
            while (n < 62)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_item(1'($urandom), $urandom, $urandom, 8'($urandom));
                    n++;
                end
                else
                begin
                    mc_now = $urandom_range(3, 25);
                    run_move(mc_now, $urandom_range(5) == 0 ? 2000000 : $urandom_range(10, 600));
                    n += mc_now + 1;
                end
            end
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        drain();
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
